@@ sv/psu_pkg.sv @@
// shared types and constants of the png scanline unfilter
// no dependencies; imported by psu_if, psu_predict, png_scanline_unfilter and psu_checker

package psu_pkg;

   // filter codes of a png row; codes of five and above are stored as none
   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } psu_filter_type;

   localparam logic [7:0] FILT_CODE_LIMIT = 8'd5;

   // configuration register indexes
   localparam logic [1:0] REG_ROW_PIXELS = 2'd0;
   localparam logic [1:0] REG_ROW_COUNT  = 2'd1;
   localparam logic [1:0] REG_HAS_ALPHA  = 2'd2;

   localparam int CSR_IW = 2;
   localparam int CSR_DW = 13;

   // channel codes
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_BLUE  = 2'd2;
   localparam logic [1:0] CH_ALPHA = 2'd3;

   localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

   // one queued result; alpha_follow marks a blue byte that expands into blue + alpha
   typedef struct packed {
      logic [7:0]  pixel_value;
      logic [1:0]  channel;
      logic [11:0] column;
      logic [11:0] out_row;
      logic        row_done;
      logic        image_done;
      logic        alpha_follow;
   } psu_result_type;

endpackage

@@ sv/psu_if.sv @@
// handshake interfaces of the png scanline unfilter: byte input, result output, csr write
// depends on psu_pkg for the csr field widths

interface psu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface psu_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  pixel_value;
   logic [1:0]  channel;
   logic [11:0] column;
   logic [11:0] out_row;
   logic        row_done;
   logic        image_done;

   modport source (output valid, output pixel_value, output channel, output column,
                   output out_row, output row_done, output image_done, input ready);
   modport sink   (input valid, input pixel_value, input channel, input column,
                   input out_row, input row_done, input image_done, output ready);
endinterface

interface psu_csr_if;
   import psu_pkg::*;
   logic              valid;
   logic              ready;
   logic [CSR_IW-1:0] index;
   logic [CSR_DW-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/psu_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module psu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ sv/psu_predict.sv @@
// png byte reconstruction: none, sub, up, average and paeth predictors
// depends on psu_pkg for the filter codes

module psu_predict import psu_pkg::*; (
   input  psu_filter_type filter_kind,
   input  logic [7:0]     x,
   input  logic [7:0]     a,
   input  logic [7:0]     b,
   input  logic [7:0]     c,
   output logic [7:0]     v
);

   function automatic logic [8:0] abs10(input logic signed [9:0] d);
      logic signed [9:0] m;
      m = (d < 0) ? -d : d;
      return m[8:0];
   endfunction

   logic signed [9:0] diff_a;
   logic signed [9:0] diff_b;
   logic signed [9:0] diff_c;
   logic [8:0]        dist_a;
   logic [8:0]        dist_b;
   logic [8:0]        dist_c;
   logic [8:0]        avg_sum;
   logic [7:0]        paeth;

   always_comb begin
      // distances of the estimate a + b - c to a, b and c
      diff_a = $signed({2'b00, b}) - $signed({2'b00, c});
      diff_b = $signed({2'b00, a}) - $signed({2'b00, c});
      diff_c = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
      dist_a = abs10(diff_a);
      dist_b = abs10(diff_b);
      dist_c = abs10(diff_c);

      if (dist_a <= dist_b && dist_a <= dist_c) begin
         paeth = a;
      end else if (dist_b <= dist_c) begin
         paeth = b;
      end else begin
         paeth = c;
      end

      avg_sum = {1'b0, a} + {1'b0, b};

      case (filter_kind)
         FILT_SUB:   v = x + a;
         FILT_UP:    v = x + b;
         FILT_AVG:   v = x + avg_sum[8:1];
         FILT_PAETH: v = x + paeth;
         default:    v = x;
      endcase
   end

endmodule

@@ sv/png_scanline_unfilter.sv @@
// top level of the png scanline unfilter
// depends on psu_pkg, psu_if, psu_ram and psu_predict

// Takes an inflated 8-bit, non-interlaced png stream one byte per transaction: a
// filter byte, then row_pixels * 3 (rgb) or * 4 (rgba) data bytes per row. Every data
// byte is rebuilt in the cycle it is accepted and lands in a two-entry result queue,
// whose head is offered on the result port. Throughput is one byte per cycle while
// the queue has a free slot; in rgb mode the blue byte expands into blue plus an
// inserted alpha of 255, and as the result port carries one transaction per cycle,
// the queue fills and input stalls. The filter byte yields no result. The previous row
// lives in a MAX_WIDTH*4 byte ram read one position ahead; the first row of an image
// reads its upper neighbours as zero, so the ram needs no clearing after reset.
// out_row is the flipped row number, clamped row count - 1 - source row. Configuration
// writes are taken at any time with ready held high and act at once; write them
// between images.

module png_scanline_unfilter import psu_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic      clock,
   input  logic      reset,
   psu_req_if.sink   req_bus,
   psu_rsp_if.source rsp_bus,
   psu_csr_if.sink   csr_bus
);

   localparam int DEPTH = MAX_WIDTH * 4;
   localparam int PW    = $clog2(DEPTH);        // byte position within a row
   localparam int WW    = $clog2(MAX_WIDTH + 1); // clamped width
   localparam int LW    = WW + 2;               // row length in bytes
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int RW    = $clog2(MAX_HEIGHT);   // source row counter

   // configuration registers
   logic [CSR_DW-1:0] row_pixels_ff;
   logic [CSR_DW-1:0] row_count_ff;
   logic              has_alpha_ff;

   // row walking state
   logic [PW-1:0]     byte_pos_ff, byte_pos_in;
   logic [PW-1:0]     col3_ff, col3_in;   // byte_pos / 3, kept alongside the position
   logic [1:0]        rem3_ff, rem3_in;   // byte_pos % 3
   logic [RW-1:0]     src_row_ff, src_row_in;
   psu_filter_type    filter_ff;
   logic              want_filter_ff;
   logic [7:0]        left_ff [4];
   logic [7:0]        upper_ff [4];

   // result queue, head in slot 0
   psu_result_type    queue_ff [2];
   logic [1:0]        count_ff;
   logic              phase_ff;           // head blue already sent, alpha pending

   logic              req_fire;
   logic              data_fire;
   logic              filter_fire;
   logic              rsp_fire;
   logic              pop;

   logic [WW-1:0]     width_c;
   logic [HW-1:0]     height_c;
   logic [LW-1:0]     row_len;
   logic [1:0]        ch;
   logic [PW-1:0]     col;
   logic              first_row;
   logic [7:0]        above_rd;
   logic [7:0]        nb_a, nb_b, nb_c;
   logic [7:0]        rebuilt;
   logic              last_byte;
   logic              last_row;
   logic [HW-1:0]     orow_full;
   psu_result_type    new_result;
   psu_result_type    head;

   // ---------------------------------------------------------------
   // configuration port, always ready
   // ---------------------------------------------------------------
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pixels_ff <= CSR_DW'(1);
         row_count_ff  <= CSR_DW'(1);
         has_alpha_ff  <= 1'b1;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_ROW_PIXELS: row_pixels_ff <= csr_bus.data;
            REG_ROW_COUNT:  row_count_ff  <= csr_bus.data;
            REG_HAS_ALPHA:  has_alpha_ff  <= csr_bus.data[0];
            default:        ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // handshakes; input stalls in reset and when both queue slots hold results
   // ---------------------------------------------------------------
   assign req_bus.ready = !reset && (count_ff != 2'd2);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign filter_fire   = req_fire && want_filter_ff;
   assign data_fire     = req_fire && !want_filter_ff;

   // ---------------------------------------------------------------
   // geometry: clamped dimensions, channel and column of this byte
   // ---------------------------------------------------------------
   always_comb begin
      if (row_pixels_ff == '0) begin
         width_c = WW'(1);
      end else if (32'(row_pixels_ff) > MAX_WIDTH) begin
         width_c = WW'(MAX_WIDTH);
      end else begin
         width_c = WW'(row_pixels_ff);
      end

      if (row_count_ff == '0) begin
         height_c = HW'(1);
      end else if (32'(row_count_ff) > MAX_HEIGHT) begin
         height_c = HW'(MAX_HEIGHT);
      end else begin
         height_c = HW'(row_count_ff);
      end

      // three bytes per pixel as 2w + w
      row_len = has_alpha_ff ? {width_c, 2'b00}
                             : ({1'b0, width_c, 1'b0} + {2'b00, width_c});

      ch  = has_alpha_ff ? byte_pos_ff[1:0] : rem3_ff;
      col = has_alpha_ff ? (byte_pos_ff >> 2) : col3_ff;

      first_row = (src_row_ff == '0);
      nb_a = left_ff[ch];
      nb_b = first_row ? 8'd0 : above_rd;
      nb_c = first_row ? 8'd0 : upper_ff[ch];

      last_byte = (LW'(byte_pos_ff) + LW'(1)) >= row_len;
      last_row  = (HW'(src_row_ff) + HW'(1)) >= height_c;
      orow_full = ((HW'(src_row_ff) + HW'(1)) <= height_c)
                  ? (height_c - HW'(1) - HW'(src_row_ff)) : '0;
   end

   psu_predict u_predict (
      .filter_kind (filter_ff),
      .x           (req_bus.data_byte),
      .a           (nb_a),
      .b           (nb_b),
      .c           (nb_c),
      .v           (rebuilt)
   );

   // ---------------------------------------------------------------
   // next position; the ram is read at it, one position ahead
   // ---------------------------------------------------------------
   always_comb begin
      byte_pos_in = byte_pos_ff;
      col3_in     = col3_ff;
      rem3_in     = rem3_ff;
      src_row_in  = src_row_ff;
      if (data_fire) begin
         if (last_byte) begin
            byte_pos_in = '0;
            col3_in     = '0;
            rem3_in     = 2'd0;
            src_row_in  = last_row ? '0 : (src_row_ff + RW'(1));
         end else begin
            byte_pos_in = byte_pos_ff + PW'(1);
            if (rem3_ff == 2'd2) begin
               rem3_in = 2'd0;
               col3_in = col3_ff + PW'(1);
            end else begin
               rem3_in = rem3_ff + 2'd1;
            end
         end
      end
   end

   // previous row store, written with each rebuilt byte
   psu_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_above_row (
      .clock   (clock),
      .wr_en   (data_fire),
      .wr_addr (byte_pos_ff),
      .wr_data (rebuilt),
      .rd_addr (byte_pos_in),
      .rd_data (above_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff    <= '0;
         col3_ff        <= '0;
         rem3_ff        <= 2'd0;
         src_row_ff     <= '0;
         filter_ff      <= FILT_NONE;
         want_filter_ff <= 1'b1;
         for (int i = 0; i < 4; i++) begin
            left_ff[i]  <= 8'd0;
            upper_ff[i] <= 8'd0;
         end
      end else begin
         byte_pos_ff <= byte_pos_in;
         col3_ff     <= col3_in;
         rem3_ff     <= rem3_in;
         src_row_ff  <= src_row_in;
         if (filter_fire) begin
            // row start: take the filter code, clear the left and upper-left neighbours
            filter_ff      <= (req_bus.data_byte < FILT_CODE_LIMIT)
                              ? psu_filter_type'(req_bus.data_byte[2:0]) : FILT_NONE;
            want_filter_ff <= 1'b0;
            for (int i = 0; i < 4; i++) begin
               left_ff[i]  <= 8'd0;
               upper_ff[i] <= 8'd0;
            end
         end else if (data_fire) begin
            left_ff[ch]  <= rebuilt;
            upper_ff[ch] <= nb_b;
            if (last_byte) begin
               want_filter_ff <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // result queue
   // ---------------------------------------------------------------
   always_comb begin
      new_result.pixel_value  = rebuilt;
      new_result.channel      = ch;
      new_result.column       = 12'(col);
      new_result.out_row      = 12'(orow_full);
      new_result.row_done     = last_byte;
      new_result.image_done   = last_byte && last_row;
      new_result.alpha_follow = !has_alpha_ff && (ch == CH_BLUE);
   end

   assign head     = queue_ff[0];
   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;
   // a blue byte in rgb mode leaves the queue only after its alpha went out
   assign pop      = rsp_fire && (!head.alpha_follow || phase_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         phase_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff <= 1'b0;
         end else if (rsp_fire) begin
            phase_ff <= 1'b1;
         end
         case ({data_fire, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   // payload slots, no reset needed
   always_ff @(posedge clock) begin
      case ({data_fire, pop})
         2'b11: begin
            if (count_ff == 2'd1) begin
               queue_ff[0] <= new_result;
            end else begin
               queue_ff[0] <= queue_ff[1];
               queue_ff[1] <= new_result;
            end
         end
         2'b01: begin
            queue_ff[0] <= queue_ff[1];
         end
         2'b10: begin
            if (count_ff == 2'd0) begin
               queue_ff[0] <= new_result;
            end else begin
               queue_ff[1] <= new_result;
            end
         end
         default: ;
      endcase
   end

   // the alpha phase of an rgb blue entry shows the inserted opaque alpha
   assign rsp_bus.valid       = (count_ff != 2'd0);
   assign rsp_bus.pixel_value = phase_ff ? ALPHA_OPAQUE : head.pixel_value;
   assign rsp_bus.channel     = phase_ff ? CH_ALPHA : head.channel;
   assign rsp_bus.column      = head.column;
   assign rsp_bus.out_row     = head.out_row;
   assign rsp_bus.row_done    = (head.alpha_follow && !phase_ff) ? 1'b0 : head.row_done;
   assign rsp_bus.image_done  = (head.alpha_follow && !phase_ff) ? 1'b0 : head.image_done;

endmodule

@@ sv/psu_checker.sv @@
// port-level checks of the png scanline unfilter, bound to the top level
// depends on psu_pkg and png_scanline_unfilter

module psu_checker import psu_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_pixel_value,
   input logic [1:0]  rsp_channel,
   input logic [11:0] rsp_column,
   input logic [11:0] rsp_out_row,
   input logic        rsp_row_done,
   input logic        rsp_image_done
);

   // a stalled result keeps its contents
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_value)
            && $stable(rsp_channel) && $stable(rsp_column) && $stable(rsp_out_row)
            && $stable(rsp_row_done) && $stable(rsp_image_done);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("result changed while stalled");

   // the last result of an image closes a row and carries flipped row zero
   property p_image_end;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_image_done |-> rsp_row_done && (rsp_out_row == 12'd0);
   endproperty
   a_image_end: assert property (p_image_end) else $error("bad end of image result");

   // input is only held off while results are waiting, once out of reset
   property p_stall_cause;
      @(posedge clock) disable iff (reset)
         !reset && !req_ready |-> rsp_valid;
   endproperty
   a_stall_cause: assert property (p_stall_cause) else $error("input stalled with no results");

   // nothing is offered straight after reset
   property p_reset_empty;
      @(posedge clock) $past(reset) |-> !rsp_valid;
   endproperty
   a_reset_empty: assert property (p_reset_empty) else $error("result offered after reset");

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_pixel_value (rsp_bus.pixel_value),
   .rsp_channel     (rsp_bus.channel),
   .rsp_column      (rsp_bus.column),
   .rsp_out_row     (rsp_bus.out_row),
   .rsp_row_done    (rsp_bus.row_done),
   .rsp_image_done  (rsp_bus.image_done)
);

@@ tb/png_scanline_unfilter_tb.sv @@
// self-checking testbench of the png scanline unfilter: byte stream in, pixel results out
// depends on psu_pkg, psu_if and the png_scanline_unfilter top level

`timescale 1ns / 1ps

module png_scanline_unfilter_tb;
   import psu_pkg::*;

   localparam int MAX_W         = 4096;
   localparam int MAX_H         = 4096;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int HOLD_OFF_LEN  = 400;

   // one expected or observed pixel result
   typedef struct {
      logic [7:0]  pixel_value;
      logic [1:0]  channel;
      logic [11:0] column;
      logic [11:0] out_row;
      logic        row_done;
      logic        image_done;
   } pixel_result_type;

   logic clock;
   logic reset;

   psu_req_if req_bus ();
   psu_rsp_if rsp_bus ();
   psu_csr_if csr_bus ();

   png_scanline_unfilter uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // shadow copy of the configuration registers, reset values
   logic [12:0] cfg_row_pixels = 13'd1;
   logic [12:0] cfg_row_count  = 13'd1;
   logic        cfg_has_alpha  = 1'b1;

   // shadow copy of the unfilter state
   logic [7:0]     prev_row_bytes [0:MAX_W*4-1];
   logic [7:0]     left_byte      [0:3];
   logic [7:0]     upleft_byte    [0:3];
   int             byte_index     = 0;
   int             source_row     = 0;
   psu_filter_type row_filter     = FILT_NONE;
   logic           await_filter   = 1'b1;

   pixel_result_type pending_pixels [$];
   pixel_result_type oldest_pixel;

   // idling mix of the current phase, in percent
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_left     = 0;

   int   bytes_sent    = 0;
   int   results_seen  = 0;
   int   images_seen   = 0;
   int   mismatches    = 0;
   longint cycle_count = 0;

   // ---------------------------------------------------------------- clock and watchdog

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycle_count, pending_pixels.size());
         $display("FAIL png_scanline_unfilter");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic int clamp_dim(input int v, input int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // paeth predictor, ties resolved towards left, then above
   function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
      int est, da, db, dc;
      est = int'(a) + int'(b) - int'(c);
      da  = (est >= int'(a)) ? est - int'(a) : int'(a) - est;
      db  = (est >= int'(b)) ? est - int'(b) : int'(b) - est;
      dc  = (est >= int'(c)) ? est - int'(c) : int'(c) - est;
      if (da <= db && da <= dc) return a;
      if (db <= dc) return b;
      return c;
   endfunction

   task automatic push_pixel(input logic [7:0] value, input int ch, input int col,
                             input int orow, input logic rdone, input logic idone);
      pixel_result_type p;
      p.pixel_value = value;
      p.channel     = ch[1:0];
      p.column      = col[11:0];
      p.out_row     = orow[11:0];
      p.row_done    = rdone;
      p.image_done  = idone;
      pending_pixels.push_back(p);
   endtask

   // rebuilds one accepted stream byte and queues the pixel results it causes
   task automatic predict_byte(input logic [7:0] x);
      int         width, height, bpp, row_len, pos, ch, col, orow;
      logic [7:0] a, b, c, v;
      logic [8:0] pair_sum;
      logic       first_row, last_byte, last_row;
      width   = clamp_dim(int'(cfg_row_pixels), MAX_W);
      height  = clamp_dim(int'(cfg_row_count), MAX_H);
      bpp     = cfg_has_alpha ? 4 : 3;
      row_len = width * bpp;
      if (await_filter) begin
         row_filter = (x < FILT_CODE_LIMIT) ? psu_filter_type'(x[2:0]) : FILT_NONE;
         byte_index = 0;
         for (int i = 0; i < 4; i++) begin
            left_byte[i]   = 8'd0;
            upleft_byte[i] = 8'd0;
         end
         await_filter = 1'b0;
         return;
      end
      pos = byte_index;
      if (pos >= MAX_W * 4) pos = MAX_W * 4 - 1;
      ch        = pos % bpp;
      col       = pos / bpp;
      first_row = (source_row == 0);
      a = left_byte[ch];
      b = first_row ? 8'd0 : prev_row_bytes[pos];
      c = first_row ? 8'd0 : upleft_byte[ch];
      pair_sum = {1'b0, a} + {1'b0, b};
      case (row_filter)
         FILT_SUB:   v = x + a;
         FILT_UP:    v = x + b;
         FILT_AVG:   v = x + pair_sum[8:1];
         FILT_PAETH: v = x + paeth_pick(a, b, c);
         default:    v = x;
      endcase
      left_byte[ch]       = v;
      upleft_byte[ch]     = b;
      prev_row_bytes[pos] = v;
      last_byte = (pos + 1 >= row_len);
      last_row  = (source_row + 1 >= height);
      orow      = (source_row + 1 <= height) ? height - 1 - source_row : 0;
      if (bpp == 3 && ch == int'(CH_BLUE)) begin
         push_pixel(v, ch, col, orow, 1'b0, 1'b0);
         push_pixel(ALPHA_OPAQUE, int'(CH_ALPHA), col, orow, last_byte, last_byte && last_row);
      end else begin
         push_pixel(v, ch, col, orow, last_byte, last_byte && last_row);
      end
      if (last_byte) begin
         await_filter = 1'b1;
         byte_index   = 0;
         source_row   = last_row ? 0 : source_row + 1;
      end else begin
         byte_index = pos + 1;
      end
   endtask

   // ---------------------------------------------------------------- result side

   // ready driver: random stalls per phase, plus a long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic check_field(input string name, input logic [11:0] want,
                              input logic [11:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // every result transaction is compared with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         results_seen++;
         if (pending_pixels.size() == 0) begin
            $error("result transaction with no expectation waiting: value %0d channel %0d",
                   rsp_bus.pixel_value, rsp_bus.channel);
            mismatches++;
         end else begin
            oldest_pixel = pending_pixels.pop_front();
            check_field("pixel_value", 12'(oldest_pixel.pixel_value), 12'(rsp_bus.pixel_value));
            check_field("channel", 12'(oldest_pixel.channel), 12'(rsp_bus.channel));
            check_field("column", oldest_pixel.column, rsp_bus.column);
            check_field("out_row", oldest_pixel.out_row, rsp_bus.out_row);
            check_field("row_done", 12'(oldest_pixel.row_done), 12'(rsp_bus.row_done));
            check_field("image_done", 12'(oldest_pixel.image_done), 12'(rsp_bus.image_done));
            if (oldest_pixel.image_done) images_seen++;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus helpers

   // offers one byte, with random idle cycles ahead of it; valid stays high afterwards
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_byte(value);
      bytes_sent++;
   endtask

   // stops offering and waits until every expected result has arrived
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      // a trailing filter byte has no result, so allow the pipeline to settle
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [12:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (index)
         REG_ROW_PIXELS: cfg_row_pixels = value;
         REG_ROW_COUNT:  cfg_row_count  = value;
         REG_HAS_ALPHA:  cfg_has_alpha  = value[0];
         default: ;
      endcase
   endtask

   // new image geometry, written only with the block idle
   task automatic load_geometry(input int pixels, input int rows, input bit alpha);
      drain_results();
      write_reg(REG_ROW_PIXELS, 13'(pixels));
      write_reg(REG_ROW_COUNT, 13'(rows));
      write_reg(REG_HAS_ALPHA, 13'(alpha));
      csr_bus.valid <= 1'b0;
   endtask

   // mostly the five known filters, now and then an unknown code
   function automatic logic [7:0] pick_filter();
      int r;
      r = $urandom_range(19);
      if (r < 18) return 8'(r % 5);
      return 8'($urandom_range(255, 5));
   endfunction

   // random byte, biased towards the extremes so that wrap-around is common
   function automatic logic [7:0] pick_data();
      int r;
      r = $urandom_range(7);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   // one whole image under the current geometry, random filters and content
   task automatic stream_image();
      int width, height, row_len;
      width   = clamp_dim(int'(cfg_row_pixels), MAX_W);
      height  = clamp_dim(int'(cfg_row_count), MAX_H);
      row_len = width * (cfg_has_alpha ? 4 : 3);
      for (int r = 0; r < height; r++) begin
         send_byte(pick_filter());
         for (int i = 0; i < row_len; i++) send_byte(pick_data());
      end
   endtask

   // ---------------------------------------------------------------- tests

   // reset geometry: one rgba pixel, one row, sub filter with every left neighbour zero
   task automatic test_reset_defaults();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_byte(8'(FILT_SUB));
      send_byte(8'hFF);
      send_byte(8'h01);
      send_byte(8'h80);
      send_byte(8'h00);
   endtask

   // one rgb pixel per row, each row with a different filter, last row an unknown code
   task automatic test_filter_codes();
      logic [7:0] codes [0:5];
      codes[0] = 8'(FILT_NONE);
      codes[1] = 8'(FILT_SUB);
      codes[2] = 8'(FILT_UP);
      codes[3] = 8'(FILT_AVG);
      codes[4] = 8'(FILT_PAETH);
      codes[5] = FILT_CODE_LIMIT;
      load_geometry(1, 6, 1'b0);
      for (int r = 0; r < 6; r++) begin
         send_byte(codes[r]);
         send_byte((r % 2 == 0) ? 8'hFF : 8'h00);
         send_byte(8'h80);
         send_byte((r % 2 == 0) ? 8'h01 : 8'hFE);
      end
   endtask

   // zero width and height act as one; filter byte 255 acts as none
   task automatic test_zero_geometry();
      load_geometry(0, 0, 1'b1);
      send_byte(8'hFF);
      send_byte(8'h7F);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'hA5);
   endtask

   // width beyond the maximum, cut short mid-row by narrowing the image so that the
   // next byte ends the row; the second row then reads the first as its upper row
   task automatic test_widest_rows();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      load_geometry(8191, 2, 1'b1);
      send_byte(pick_filter());
      for (int i = 0; i < 40; i++) send_byte(pick_data());
      load_geometry(4, 2, 1'b1);
      send_byte(pick_data());
      send_byte(pick_filter());
      for (int i = 0; i < 16; i++) send_byte(pick_data());
   endtask

   // height beyond the maximum clamps to 4096 rows, so out_row starts at 4095; the
   // image is then closed early by lowering the height below the current row
   task automatic test_tallest_image();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      load_geometry(1, 8191, 1'b1);
      for (int r = 0; r < 3; r++) begin
         send_byte(pick_filter());
         for (int i = 0; i < 4; i++) send_byte(pick_data());
      end
      load_geometry(1, 1, 1'b1);
      send_byte(pick_filter());
      for (int i = 0; i < 4; i++) send_byte(pick_data());
   endtask

   // random small images under one idling mix, until enough bytes have gone in
   task automatic test_random_images(input int idle_pct, input int stall_pct,
                                     input int byte_goal);
      int start_count, pixels, rows;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      start_count   = bytes_sent;
      while (bytes_sent - start_count < byte_goal) begin
         pixels = ($urandom_range(99) < 85) ? $urandom_range(6, 1) : $urandom_range(48, 7);
         rows   = $urandom_range(5, 1);
         load_geometry(pixels, rows, 1'($urandom_range(1)));
         stream_image();
      end
   endtask

   // output held off for a long stretch while input keeps offering, so the block backs up
   task automatic test_output_hold_off();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      load_geometry(16, 4, 1'b1);
      hold_left = HOLD_OFF_LEN;
      stream_image();
      load_geometry(5, 3, 1'b0);
      hold_left = HOLD_OFF_LEN;
      stream_image();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= 8'd0;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= REG_ROW_PIXELS;
      csr_bus.data      <= 13'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_filter_codes();
      test_zero_geometry();
      test_widest_rows();
      test_tallest_image();
      test_random_images(0, 0, 300);
      test_random_images(51, 0, 300);
      test_random_images(0, 51, 300);
      test_random_images(34, 34, 300);
      test_output_hold_off();
      drain_results();

      $display("run covered %0d stream bytes and %0d pixel results over %0d images",
               bytes_sent, results_seen, images_seen);
      $display("rgb and rgba, all filters, clamped and zero geometry, mid-image resizing");
      if (mismatches == 0) begin
         $display("PASS png_scanline_unfilter");
      end else begin
         $display("FAIL png_scanline_unfilter");
      end
      $finish;
   end

endmodule
